[sv/hkl_pkg.sv]
// Shared types, constants and helpers for the hashed keyword lookup block.
package hkl_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_DEPTH   = 2 * TABLE_DEPTH;
  localparam int RAM_ADDR_W  = ADDR_W + 1;

  // Field widths fixed by the interface.
  localparam int HASH_W  = 31;
  localparam int RUN_W   = 32;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;

  // Hash constants.
  localparam logic [RUN_W-1:0] HASH_SEED = 32'd13131;

  // Word terminators.
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;

  // Request types.
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Table selection.
  localparam logic TBL_CMD = 1'b0;
  localparam logic TBL_KEY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CMD_COUNT = 1'b0;
  localparam logic REG_KEY_COUNT = 1'b1;

  // Search start request from the front end to the search engine.
  typedef struct packed {
    logic              start;
    logic              sel;
    logic [HASH_W-1:0] key;
    logic [CNT_W-1:0]  count;
  } srch_req_t;

  // Search engine status and result.
  typedef struct packed {
    logic              idle;
    logic              done;
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [HASH_W-1:0] key;
  } srch_rsp_t;

  // True for a character that ends a word.
  function automatic logic is_terminator(input logic [CHAR_W-1:0] ch);
    return (ch == CHAR_NUL) || (ch == CHAR_CR) || (ch == CHAR_LF);
  endfunction

  // Clamp a configured count to the table depth.
  function automatic logic [CNT_W-1:0] sat_count(input logic [COUNT_W-1:0] cnt);
    if (32'(cnt) > TABLE_DEPTH) begin
      return CNT_W'(TABLE_DEPTH);
    end else begin
      return CNT_W'(cnt);
    end
  endfunction

endpackage

[sv/hashed_keyword_lookup.sv]
// Top level of the hashed keyword lookup block.
//
// Words arrive one character per request on the req channel (req_valid,
// req_ready). A character request updates a 32-bit running hash,
// hash * 13131 + char, and is taken every cycle while req_ready is high.
// A table write request (req_type = write) stores entry_hash into slot
// entry_index of the command or key table and gives no result.
// A NUL, CR or LF ends the word: the hash is masked to 31 bits and
// binary-searched in the selected table, and one result is sent on the res
// channel (res_valid, res_ready) with found, match_index and word_hash.
// Each search step is a check state, which reads the midpoint from the RAM,
// and a compare state on the registered read data. req_ready is low while
// the search runs.
// The result sits in an output register; while the receiver stalls, further
// characters and writes are still taken. A second terminator is searched,
// and req_ready then stays low until the pending result is taken.
// Reset clears the running hash, both counts and the result valid. Table
// contents are not cleared and must be written before they are searched.
// Counts are written on the cfg channel, which is always ready.
module hashed_keyword_lookup (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel.
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        req_type,
  input  logic                        table_select,
  input  logic [hkl_pkg::CHAR_W-1:0]  char_code,
  input  logic [hkl_pkg::IDX_W-1:0]   entry_index,
  input  logic [hkl_pkg::HASH_W-1:0]  entry_hash,
  // Result channel.
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        found,
  output logic [hkl_pkg::IDX_W-1:0]   match_index,
  output logic [hkl_pkg::HASH_W-1:0]  word_hash,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [hkl_pkg::COUNT_W-1:0] cfg_data
);

  logic [hkl_pkg::RUN_W-1:0]      running_hash;
  logic [hkl_pkg::COUNT_W-1:0]    cmd_count;
  logic [hkl_pkg::COUNT_W-1:0]    key_count;
  logic                           req_fire;
  logic                           is_write;
  logic                           is_term;
  logic                           wr_in_range;
  logic                           ram_we;
  logic [hkl_pkg::RAM_ADDR_W-1:0] ram_addr;
  logic [hkl_pkg::RAM_ADDR_W-1:0] srch_addr;
  logic [hkl_pkg::HASH_W-1:0]     ram_rdata;
  logic                           take;
  hkl_pkg::srch_req_t             srch_req;
  hkl_pkg::srch_rsp_t             srch_rsp;

  assign cfg_ready = 1'b1;
  assign req_ready = srch_rsp.idle;
  assign req_fire  = req_valid && req_ready;
  assign is_write  = (req_type == hkl_pkg::REQ_WRITE);
  assign is_term   = hkl_pkg::is_terminator(char_code);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_count <= '0;
      key_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hkl_pkg::REG_CMD_COUNT: cmd_count <= cfg_data;
        hkl_pkg::REG_KEY_COUNT: key_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running hash: advanced by characters, cleared at the end of each word.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (req_fire && !is_write) begin
      if (is_term) begin
        running_hash <= '0;
      end else begin
        running_hash <= hkl_pkg::RUN_W'(running_hash * hkl_pkg::HASH_SEED)
                        + hkl_pkg::RUN_W'(char_code);
      end
    end
  end

  // Search start on a terminator.
  always_comb begin
    srch_req.start = req_fire && !is_write && is_term;
    srch_req.sel   = table_select;
    srch_req.key   = running_hash[hkl_pkg::HASH_W-1:0];
    srch_req.count = (table_select == hkl_pkg::TBL_CMD) ? hkl_pkg::sat_count(cmd_count)
                                                        : hkl_pkg::sat_count(key_count);
  end

  // Table RAM port: writes while idle, search reads otherwise.
  assign wr_in_range = (32'(entry_index) < hkl_pkg::TABLE_DEPTH);
  assign ram_we      = req_fire && is_write && wr_in_range;
  assign ram_addr    = srch_rsp.idle
                       ? {table_select, hkl_pkg::ADDR_W'(entry_index)}
                       : srch_addr;

  hkl_table_ram #(
    .DEPTH (hkl_pkg::RAM_DEPTH),
    .WIDTH (hkl_pkg::HASH_W)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (entry_hash),
    .rdata (ram_rdata)
  );

  hkl_search u_search (
    .clk   (clk),
    .rst   (rst),
    .req   (srch_req),
    .take  (take),
    .rdata (ram_rdata),
    .raddr (srch_addr),
    .rsp   (srch_rsp)
  );

  // Output register, loaded when the search is done and the slot is free.
  assign take = srch_rsp.done && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found       <= srch_rsp.found;
      match_index <= srch_rsp.index;
      word_hash   <= srch_rsp.key;
    end
  end

endmodule

[sv/hkl_table_ram.sv]
// Single-port synchronous RAM holding both hash tables.
module hkl_table_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request; read data is registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/hkl_search.sv]
// Binary search engine that walks a sorted table through the RAM read port.
module hkl_search (
  input  logic                             clk,
  input  logic                             rst,
  input  hkl_pkg::srch_req_t               req,
  input  logic                             take,
  input  logic [hkl_pkg::HASH_W-1:0]       rdata,
  output logic [hkl_pkg::RAM_ADDR_W-1:0]   raddr,
  output hkl_pkg::srch_rsp_t               rsp
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_CMP   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                       state, state_next;
  logic                         sel;
  logic [hkl_pkg::HASH_W-1:0]   key;
  logic [hkl_pkg::CNT_W-1:0]    lo, lo_next;
  logic [hkl_pkg::CNT_W-1:0]    hi_p1, hi_p1_next;
  logic [hkl_pkg::ADDR_W-1:0]   mid, mid_next;
  logic                         found, found_next;
  logic [hkl_pkg::CNT_W:0]      mid_sum;
  logic [hkl_pkg::ADDR_W-1:0]   mid_calc;

  // Midpoint of the inclusive range [lo, hi_p1 - 1].
  assign mid_sum  = {1'b0, lo} + {1'b0, hi_p1} - (hkl_pkg::CNT_W + 1)'(1);
  assign mid_calc = hkl_pkg::ADDR_W'(mid_sum >> 1);

  // The read address is presented in the check state; data arrives in compare.
  assign raddr = {sel, mid_calc};

  // Next-state logic for the search loop.
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_p1_next = hi_p1;
    mid_next   = mid;
    found_next = found;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          lo_next    = '0;
          hi_p1_next = req.count;
          found_next = 1'b0;
          mid_next   = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (lo < hi_p1) begin
          mid_next   = mid_calc;
          state_next = S_CMP;
        end else begin
          found_next = 1'b0;
          mid_next   = '0;
          state_next = S_DONE;
        end
      end
      S_CMP: begin
        if (key == rdata) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else if (key > rdata) begin
          lo_next    = hkl_pkg::CNT_W'(mid) + hkl_pkg::CNT_W'(1);
          state_next = S_CHECK;
        end else begin
          hi_p1_next = hkl_pkg::CNT_W'(mid);
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search registers.
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi_p1 <= hi_p1_next;
    mid   <= mid_next;
    found <= found_next;
    if (state == S_IDLE && req.start) begin
      sel <= req.sel;
      key <= req.key;
    end
  end

  // Status and result toward the front end.
  always_comb begin
    rsp.idle  = (state == S_IDLE);
    rsp.done  = (state == S_DONE);
    rsp.found = found;
    rsp.index = found ? hkl_pkg::IDX_W'(mid) : '0;
    rsp.key   = key;
  end

endmodule
